@@ rtl/core/pgc_pkg.sv @@
// Shared constants, control struct and width helper for the payload gravity
// compensation block. No dependencies; all rtl/core files but pgc_if use it.
package pgc_pkg;

  localparam int MASS_W = 16;
  localparam int COM_W  = 18;
  localparam int CFG_IDX_W = 3;

  // -9.81 m/s^2 in Q16, negated so the lanes multiply directly
  localparam int GRAV_W = 21;
  localparam logic signed [GRAV_W-1:0] NEG_GRAV = -21'sd642908;

  // right shifts of the rounding steps
  localparam int W_SHIFT = 16;
  localparam int G_SHIFT = 16;
  localparam int F_SHIFT = 14;
  localparam int T_SHIFT = 12;

  localparam int LANES        = 3;
  localparam int WRENCH_AXES  = 6;
  localparam int LANE_STAGES  = 6;
  localparam int MERGE_STAGES = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MASS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COM_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COM_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COM_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_MODE = 3'd7;

  // raw reset bits of the sensor rotation rows
  localparam logic [63:0] ROT_ROW0_RST = 64'd65536;
  localparam logic [63:0] ROT_ROW1_RST = 64'd4294967296;
  localparam logic [63:0] ROT_ROW2_RST = 64'd1125899906842624;

  typedef struct packed {
    logic adv;       // pipeline moves one stage
    logic sub_mode;  // 1: subtract load wrench, 0: add it
  } pgc_ctrl_t;

  // width of the rounded load force out of a lane
  function automatic int force_w(input int rot_w);
    int w;
    w = 2 * rot_w + 2;        // three-term dot product
    w = w + 1 - W_SHIFT;      // rounded direction
    w = w + GRAV_W;           // times gravity
    w = w + 1 - G_SHIFT;      // rounded gravity
    w = w + MASS_W + 1;       // times mass
    w = w + 1 - F_SHIFT;      // rounded force
    return w;
  endfunction

endpackage

@@ rtl/core/pgc_if.sv @@
// Stream interfaces of the payload gravity compensation block: input sample
// word and compensated wrench word, valid/ready handshake. No dependencies.
interface pgc_in_if #(
  parameter int WRENCH_WIDTH = 24,
  parameter int ROT_WIDTH    = 18
);
  logic                           valid;
  logic                           ready;
  logic signed [WRENCH_WIDTH-1:0] force_x;
  logic signed [WRENCH_WIDTH-1:0] force_y;
  logic signed [WRENCH_WIDTH-1:0] force_z;
  logic signed [WRENCH_WIDTH-1:0] torque_x;
  logic signed [WRENCH_WIDTH-1:0] torque_y;
  logic signed [WRENCH_WIDTH-1:0] torque_z;
  logic signed [ROT_WIDTH-1:0]    ee_rot_r20;
  logic signed [ROT_WIDTH-1:0]    ee_rot_r21;
  logic signed [ROT_WIDTH-1:0]    ee_rot_r22;

  modport source (
    output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
           ee_rot_r20, ee_rot_r21, ee_rot_r22,
    input  ready
  );
  modport sink (
    input  valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
           ee_rot_r20, ee_rot_r21, ee_rot_r22,
    output ready
  );
endinterface

interface pgc_out_if #(
  parameter int WRENCH_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [WRENCH_WIDTH-1:0] comp_force_x;
  logic signed [WRENCH_WIDTH-1:0] comp_force_y;
  logic signed [WRENCH_WIDTH-1:0] comp_force_z;
  logic signed [WRENCH_WIDTH-1:0] comp_torque_x;
  logic signed [WRENCH_WIDTH-1:0] comp_torque_y;
  logic signed [WRENCH_WIDTH-1:0] comp_torque_z;

  modport source (
    output valid, comp_force_x, comp_force_y, comp_force_z,
           comp_torque_x, comp_torque_y, comp_torque_z,
    input  ready
  );
  modport sink (
    input  valid, comp_force_x, comp_force_y, comp_force_z,
           comp_torque_x, comp_torque_y, comp_torque_z,
    output ready
  );
endinterface

@@ rtl/core/pgc_lane.sv @@
// One force axis: gravity direction dot product, gravity scale, mass scale.
// Six register stages, all moving on adv_i. Depends on pgc_pkg.
module pgc_lane #(
  parameter int ROT_WIDTH = 18
) (
  input  logic                                    clk_i,
  input  logic                                    adv_i,
  input  logic [3*ROT_WIDTH-1:0]                  e_i,     // r20, r21, r22 from low bits
  input  logic [3*ROT_WIDTH-1:0]                  s_i,     // S[0][i], S[1][i], S[2][i]
  input  logic [pgc_pkg::MASS_W-1:0]              mass_i,
  output logic signed [pgc_pkg::force_w(ROT_WIDTH)-1:0] force_o
);

  localparam int P_W   = 2 * ROT_WIDTH;
  localparam int SUM_W = P_W + 2;
  localparam int W16_W = SUM_W + 1 - pgc_pkg::W_SHIFT;
  localparam int GP_W  = W16_W + pgc_pkg::GRAV_W;
  localparam int G_W   = GP_W + 1 - pgc_pkg::G_SHIFT;
  localparam int MF_W  = G_W + pgc_pkg::MASS_W + 1;
  localparam int F_W   = pgc_pkg::force_w(ROT_WIDTH);

  localparam logic signed [SUM_W:0] W_HALF = (SUM_W+1)'(1) <<< (pgc_pkg::W_SHIFT - 1);
  localparam logic signed [GP_W:0]  G_HALF = (GP_W+1)'(1) <<< (pgc_pkg::G_SHIFT - 1);
  localparam logic signed [MF_W:0]  F_HALF = (MF_W+1)'(1) <<< (pgc_pkg::F_SHIFT - 1);

  logic signed [ROT_WIDTH-1:0] e_s [3];
  logic signed [ROT_WIDTH-1:0] s_s [3];
  logic signed [P_W-1:0]       prod_d [3];
  logic signed [P_W-1:0]       prod_q [3];
  logic signed [SUM_W:0]       w_rnd, w_sh;
  logic signed [W16_W-1:0]     w16_d, w16_q;
  logic signed [GP_W-1:0]      gp_d, gp_q;
  logic signed [GP_W:0]        g_rnd, g_sh;
  logic signed [G_W-1:0]       g_d, g_q;
  logic signed [pgc_pkg::MASS_W:0] mass_s;
  logic signed [MF_W-1:0]      mf_d, mf_q;
  logic signed [MF_W:0]        f_rnd, f_sh;
  logic signed [F_W-1:0]       f_d, f_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e_s[k]    = e_i[k*ROT_WIDTH +: ROT_WIDTH];
      s_s[k]    = s_i[k*ROT_WIDTH +: ROT_WIDTH];
      prod_d[k] = P_W'(e_s[k]) * P_W'(s_s[k]);
    end
  end

  always_comb begin
    w_rnd = (SUM_W+1)'(prod_q[0]) + (SUM_W+1)'(prod_q[1])
          + (SUM_W+1)'(prod_q[2]) + W_HALF;
    w_sh  = w_rnd >>> pgc_pkg::W_SHIFT;
    w16_d = w_sh[W16_W-1:0];

    gp_d  = GP_W'(w16_q) * GP_W'(pgc_pkg::NEG_GRAV);

    g_rnd = (GP_W+1)'(gp_q) + G_HALF;
    g_sh  = g_rnd >>> pgc_pkg::G_SHIFT;
    g_d   = g_sh[G_W-1:0];

    mass_s = $signed({1'b0, mass_i});
    mf_d   = MF_W'(g_q) * MF_W'(mass_s);

    f_rnd = (MF_W+1)'(mf_q) + F_HALF;
    f_sh  = f_rnd >>> pgc_pkg::F_SHIFT;
    f_d   = f_sh[F_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      w16_q  <= w16_d;
      gp_q   <= gp_d;
      g_q    <= g_d;
      mf_q   <= mf_d;
      f_q    <= f_d;
    end
  end

  assign force_o = f_q;

endmodule

@@ rtl/core/pgc_merge.sv @@
// Merging stage: load torque from the three lane forces and the COM offset,
// then add or subtract the load wrench and saturate. Depends on pgc_pkg.
module pgc_merge #(
  parameter int WRENCH_WIDTH = 24,
  parameter int FORCE_W      = 33
) (
  input  logic                                  clk_i,
  input  pgc_pkg::pgc_ctrl_t                    ctrl_i,
  input  logic [3*FORCE_W-1:0]                  force_i,
  input  logic [3*pgc_pkg::COM_W-1:0]           com_i,
  input  logic [pgc_pkg::WRENCH_AXES*WRENCH_WIDTH-1:0] meas_i,
  output logic [pgc_pkg::WRENCH_AXES*WRENCH_WIDTH-1:0] res_o
);

  localparam int COM_W = pgc_pkg::COM_W;
  localparam int AX    = pgc_pkg::WRENCH_AXES;
  localparam int CF_W  = COM_W + FORCE_W;
  localparam int D_W   = CF_W + 1;
  localparam int T_W   = D_W + 1 - pgc_pkg::T_SHIFT;
  localparam int S_W   = ((T_W > WRENCH_WIDTH) ? T_W : WRENCH_WIDTH) + 1;

  localparam logic signed [D_W:0] T_HALF = (D_W+1)'(1) <<< (pgc_pkg::T_SHIFT - 1);
  localparam logic signed [S_W-1:0] SAT_HI =
    {{(S_W-WRENCH_WIDTH+1){1'b0}}, {(WRENCH_WIDTH-1){1'b1}}};
  localparam logic signed [S_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [FORCE_W-1:0] f_s [3];
  logic signed [COM_W-1:0]   c_s [3];
  logic signed [CF_W-1:0]    prod_d [6];
  logic signed [CF_W-1:0]    prod_q [6];
  logic signed [FORCE_W-1:0] f1_q [3];
  logic signed [FORCE_W-1:0] f2_q [3];
  logic [AX*WRENCH_WIDTH-1:0] meas1_q, meas2_q;
  logic signed [D_W:0]       t_rnd [3];
  logic signed [D_W:0]       t_sh [3];
  logic signed [T_W-1:0]     torque_d [3];
  logic signed [T_W-1:0]     torque_q [3];
  logic signed [S_W-1:0]     load [AX];
  logic signed [S_W-1:0]     meas_s [AX];
  logic signed [S_W-1:0]     sum [AX];
  logic [AX*WRENCH_WIDTH-1:0] res_d, res_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      f_s[k] = force_i[k*FORCE_W +: FORCE_W];
      c_s[k] = com_i[k*COM_W +: COM_W];
    end
    // cross product terms, pairs subtract in the next stage
    prod_d[0] = CF_W'(c_s[1]) * CF_W'(f_s[2]);
    prod_d[1] = CF_W'(c_s[2]) * CF_W'(f_s[1]);
    prod_d[2] = CF_W'(c_s[2]) * CF_W'(f_s[0]);
    prod_d[3] = CF_W'(c_s[0]) * CF_W'(f_s[2]);
    prod_d[4] = CF_W'(c_s[0]) * CF_W'(f_s[1]);
    prod_d[5] = CF_W'(c_s[1]) * CF_W'(f_s[0]);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_rnd[k]    = (D_W+1)'(prod_q[2*k]) - (D_W+1)'(prod_q[2*k+1]) + T_HALF;
      t_sh[k]     = t_rnd[k] >>> pgc_pkg::T_SHIFT;
      torque_d[k] = t_sh[k][T_W-1:0];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      load[k]   = S_W'(f2_q[k]);
      load[k+3] = S_W'(torque_q[k]);
    end
    for (int k = 0; k < AX; k++) begin
      meas_s[k] = S_W'($signed(meas2_q[k*WRENCH_WIDTH +: WRENCH_WIDTH]));
      sum[k]    = ctrl_i.sub_mode ? (meas_s[k] - load[k]) : (meas_s[k] + load[k]);
      if (sum[k] > SAT_HI) begin
        res_d[k*WRENCH_WIDTH +: WRENCH_WIDTH] = SAT_HI[WRENCH_WIDTH-1:0];
      end else if (sum[k] < SAT_LO) begin
        res_d[k*WRENCH_WIDTH +: WRENCH_WIDTH] = SAT_LO[WRENCH_WIDTH-1:0];
      end else begin
        res_d[k*WRENCH_WIDTH +: WRENCH_WIDTH] = sum[k][WRENCH_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      prod_q   <= prod_d;
      f1_q     <= f_s;
      meas1_q  <= meas_i;
      torque_q <= torque_d;
      f2_q     <= f1_q;
      meas2_q  <= meas1_q;
      res_q    <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ rtl/core/payload_gravity_compensation.sv @@
// Payload gravity compensation for a six-axis force/torque sensor.
//
// in_i carries one sensor word per handshake: the measured wrench plus the
// bottom row of the world-to-end-effector rotation. out_o returns one
// compensated wrench word for every input word, in order. The configuration
// port (cfg_we_i, cfg_idx_i, cfg_data_i) writes mass, COM offset, the
// end-effector-to-sensor rotation rows and the add/subtract mode; write it
// only while no word is in flight.
//
// From input handshake to out_o.valid a word passes six stages in each of
// the three force lanes (dot product, rounding, gravity multiply, rounding,
// mass multiply, rounding) and three in the merge stage (cross product
// multiply, torque rounding, add/subtract with saturation). One word per
// cycle is taken and returned while the receiver keeps up.
// A one-word skid register behind the merge stage catches the result when
// out_o.ready is low; the pipeline then holds and in_i.ready drops until the
// skid word is taken. Reset clears all valid state and loads the register
// reset values; no word is in flight after reset.
// Depends on pgc_pkg, pgc_if, pgc_lane, pgc_merge.
module payload_gravity_compensation #(
  parameter int WRENCH_WIDTH = 24,
  parameter int ROT_WIDTH    = 18
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pgc_in_if.sink                          in_i,
  pgc_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [pgc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [3*ROT_WIDTH-1:0]          cfg_data_i
);

  localparam int F_W    = pgc_pkg::force_w(ROT_WIDTH);
  localparam int AX     = pgc_pkg::WRENCH_AXES;
  localparam int ROW_W  = 3 * ROT_WIDTH;
  localparam int COM_W  = pgc_pkg::COM_W;
  localparam int LANE_L = pgc_pkg::LANE_STAGES;
  localparam int LAT    = pgc_pkg::LANE_STAGES + pgc_pkg::MERGE_STAGES;

  // configuration registers
  logic [pgc_pkg::MASS_W-1:0] mass_q;
  logic [3*COM_W-1:0]         com_q;
  logic [ROW_W-1:0]           rot_row_q [3];
  logic                       sub_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q       <= '0;
      com_q        <= '0;
      rot_row_q[0] <= pgc_pkg::ROT_ROW0_RST[ROW_W-1:0];
      rot_row_q[1] <= pgc_pkg::ROT_ROW1_RST[ROW_W-1:0];
      rot_row_q[2] <= pgc_pkg::ROT_ROW2_RST[ROW_W-1:0];
      sub_mode_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pgc_pkg::CFG_MASS:     mass_q <= cfg_data_i[pgc_pkg::MASS_W-1:0];
        pgc_pkg::CFG_COM_X:    com_q[0*COM_W +: COM_W] <= cfg_data_i[COM_W-1:0];
        pgc_pkg::CFG_COM_Y:    com_q[1*COM_W +: COM_W] <= cfg_data_i[COM_W-1:0];
        pgc_pkg::CFG_COM_Z:    com_q[2*COM_W +: COM_W] <= cfg_data_i[COM_W-1:0];
        pgc_pkg::CFG_ROT_ROW0: rot_row_q[0] <= cfg_data_i;
        pgc_pkg::CFG_ROT_ROW1: rot_row_q[1] <= cfg_data_i;
        pgc_pkg::CFG_ROT_ROW2: rot_row_q[2] <= cfg_data_i;
        pgc_pkg::CFG_SUB_MODE: sub_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake and valid pipeline
  logic                       skid_valid_q;
  logic [AX*WRENCH_WIDTH-1:0] skid_q;
  logic [LAT-1:0]             v_q;
  logic                       adv;
  logic                       in_acc;
  pgc_pkg::pgc_ctrl_t         ctrl;

  assign adv      = !skid_valid_q;
  assign in_i.ready = !skid_valid_q;
  assign in_acc   = in_i.valid && !skid_valid_q;
  assign ctrl.adv      = adv;
  assign ctrl.sub_mode = sub_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q          <= '0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_o.ready) begin
        skid_valid_q <= 1'b0;
      end
    end else begin
      v_q <= {v_q[LAT-2:0], in_acc};
      if (v_q[LAT-1] && !out_o.ready) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // measured wrench rides alongside the lanes
  logic [AX*WRENCH_WIDTH-1:0] meas_in;
  logic [AX*WRENCH_WIDTH-1:0] meas_q [LANE_L];

  assign meas_in = {in_i.torque_z, in_i.torque_y, in_i.torque_x,
                    in_i.force_z, in_i.force_y, in_i.force_x};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meas_q[0] <= meas_in;
      for (int k = 1; k < LANE_L; k++) begin
        meas_q[k] <= meas_q[k-1];
      end
    end
  end

  // force lanes, one per sensor axis
  logic [ROW_W-1:0]         ee_row;
  logic [pgc_pkg::LANES*F_W-1:0] force_all;

  assign ee_row = {in_i.ee_rot_r22, in_i.ee_rot_r21, in_i.ee_rot_r20};

  for (genvar i = 0; i < pgc_pkg::LANES; i++) begin : g_lane
    logic [ROW_W-1:0] col;
    assign col = {rot_row_q[2][i*ROT_WIDTH +: ROT_WIDTH],
                  rot_row_q[1][i*ROT_WIDTH +: ROT_WIDTH],
                  rot_row_q[0][i*ROT_WIDTH +: ROT_WIDTH]};

    pgc_lane #(
      .ROT_WIDTH (ROT_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .e_i     (ee_row),
      .s_i     (col),
      .mass_i  (mass_q),
      .force_o (force_all[i*F_W +: F_W])
    );
  end

  logic [AX*WRENCH_WIDTH-1:0] res;

  pgc_merge #(
    .WRENCH_WIDTH (WRENCH_WIDTH),
    .FORCE_W      (F_W)
  ) u_merge (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .force_i (force_all),
    .com_i   (com_q),
    .meas_i  (meas_q[LANE_L-1]),
    .res_o   (res)
  );

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      skid_q <= res;
    end
  end

  logic [AX*WRENCH_WIDTH-1:0] out_word;

  assign out_word            = skid_valid_q ? skid_q : res;
  assign out_o.valid         = skid_valid_q || v_q[LAT-1];
  assign out_o.comp_force_x  = out_word[0*WRENCH_WIDTH +: WRENCH_WIDTH];
  assign out_o.comp_force_y  = out_word[1*WRENCH_WIDTH +: WRENCH_WIDTH];
  assign out_o.comp_force_z  = out_word[2*WRENCH_WIDTH +: WRENCH_WIDTH];
  assign out_o.comp_torque_x = out_word[3*WRENCH_WIDTH +: WRENCH_WIDTH];
  assign out_o.comp_torque_y = out_word[4*WRENCH_WIDTH +: WRENCH_WIDTH];
  assign out_o.comp_torque_z = out_word[5*WRENCH_WIDTH +: WRENCH_WIDTH];

endmodule

@@ rtl/core/pgc_checker.sv @@
// Port-level checks for payload_gravity_compensation and the bind that
// attaches them. Depends on pgc_pkg and the top level's ports.
module pgc_checker #(
  parameter int DATA_W = 144
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_data
);

  localparam int LAT     = pgc_pkg::LANE_STAGES + pgc_pkg::MERGE_STAGES;
  localparam int MAX_FLT = LAT + 1;
  localparam int CNT_W   = $clog2(MAX_FLT + 1);

  logic             in_hs, out_hs;
  logic [CNT_W-1:0] flight_q;

  assign in_hs  = in_valid && in_ready;
  assign out_hs = out_valid && out_ready;

  // words accepted but not yet returned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else if (in_hs && !out_hs) begin
      flight_q <= flight_q + CNT_W'(1);
    end else if (out_hs && !in_hs) begin
      flight_q <= flight_q - CNT_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result word withdrawn without handshake");

  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without an output stall");

  a_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid || flight_q != '0) && (flight_q <= CNT_W'(MAX_FLT)))
    else $error("result count does not match accepted words");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs && flight_q == '0 |-> ##LAT out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind payload_gravity_compensation pgc_checker #(
  .DATA_W (6 * WRENCH_WIDTH)
) u_pgc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  ({out_o.comp_torque_z, out_o.comp_torque_y, out_o.comp_torque_x,
               out_o.comp_force_z, out_o.comp_force_y, out_o.comp_force_x})
);

@@ tb/payload_gravity_compensation_tb.sv @@
// Self-checking testbench for payload_gravity_compensation: random and directed
// sensor words against a bit-exact wrench predictor, with random stalls on both sides.
// Depends on pgc_pkg, pgc_if and the payload_gravity_compensation RTL.
module payload_gravity_compensation_tb;
  import pgc_pkg::*;

  localparam int WW = 24;
  localparam int RW = 18;
  localparam int RROW_W = 3 * RW;
  localparam longint GRAV_Q16 = 642908;
  localparam longint WMAX = (longint'(1) << (WW - 1)) - 1;
  localparam longint WMIN = -(longint'(1) << (WW - 1));
  localparam logic signed [RW-1:0] RMAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic signed [RW-1:0] RMIN = {1'b1, {(RW-1){1'b0}}};
  localparam logic signed [RW-1:0] UNIT = 18'sd65536;
  localparam int NUM_PHASES = 10;
  localparam int WORDS_PER_PHASE = 128;
  localparam int HOLD_CYCLES = 120;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic signed [WW-1:0] meas[6];  // fx fy fz tx ty tz
    logic signed [RW-1:0] e[3];     // bottom row of ee rotation
  } sample_t;

  typedef struct {
    logic signed [WW-1:0] axis[6];
  } wrench_t;

  class compensation_model;
    logic [MASS_W-1:0]       mass;
    logic signed [COM_W-1:0] com[3];
    logic [RROW_W-1:0]       rot_row[3];
    bit                      sub_mode;
    wrench_t                 expected_wrenches[$];
    int                      errors;
    int                      checked;

    function new();
      mass = '0;
      for (int i = 0; i < 3; i++) com[i] = '0;
      rot_row[0] = ROT_ROW0_RST[RROW_W-1:0];
      rot_row[1] = ROT_ROW1_RST[RROW_W-1:0];
      rot_row[2] = ROT_ROW2_RST[RROW_W-1:0];
      sub_mode = 1'b1;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RROW_W-1:0] data);
      case (idx)
        CFG_MASS:     mass = data[MASS_W-1:0];
        CFG_COM_X:    com[0] = data[COM_W-1:0];
        CFG_COM_Y:    com[1] = data[COM_W-1:0];
        CFG_COM_Z:    com[2] = data[COM_W-1:0];
        CFG_ROT_ROW0: rot_row[0] = data;
        CFG_ROT_ROW1: rot_row[1] = data;
        CFG_ROT_ROW2: rot_row[2] = data;
        CFG_SUB_MODE: sub_mode = data[0];
        default: ;
      endcase
    endfunction

    // add half an LSB, then floor
    function longint round_shift(longint x, int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function logic signed [WW-1:0] clip(longint x);
      if (x > WMAX) return WMAX[WW-1:0];
      if (x < WMIN) return WMIN[WW-1:0];
      return x[WW-1:0];
    endfunction

    function wrench_t compensate(sample_t s);
      longint w32, w16, g, m, sum;
      longint f[3], t[3], c[3];
      logic signed [RW-1:0] entry;
      wrench_t r;
      m = longint'(mass);
      for (int i = 0; i < 3; i++) c[i] = longint'(com[i]);
      for (int i = 0; i < 3; i++) begin
        w32 = 0;
        for (int j = 0; j < 3; j++) begin
          entry = rot_row[j][i*RW +: RW];
          w32 += longint'(s.e[j]) * longint'(entry);
        end
        w16 = round_shift(w32, W_SHIFT);
        g = round_shift(-GRAV_Q16 * w16, G_SHIFT);
        f[i] = round_shift(m * g, F_SHIFT);
      end
      // torque from the already rounded load force
      t[0] = round_shift(c[1] * f[2] - c[2] * f[1], T_SHIFT);
      t[1] = round_shift(c[2] * f[0] - c[0] * f[2], T_SHIFT);
      t[2] = round_shift(c[0] * f[1] - c[1] * f[0], T_SHIFT);
      for (int i = 0; i < 3; i++) begin
        sum = sub_mode ? longint'(s.meas[i]) - f[i] : longint'(s.meas[i]) + f[i];
        r.axis[i] = clip(sum);
        sum = sub_mode ? longint'(s.meas[3+i]) - t[i] : longint'(s.meas[3+i]) + t[i];
        r.axis[3+i] = clip(sum);
      end
      return r;
    endfunction

    function void note_sample(sample_t s);
      expected_wrenches.push_back(compensate(s));
    endfunction

    function string axis_name(int i);
      case (i)
        0: return "comp_force_x";
        1: return "comp_force_y";
        2: return "comp_force_z";
        3: return "comp_torque_x";
        4: return "comp_torque_y";
        default: return "comp_torque_z";
      endcase
    endfunction

    function void check_wrench(wrench_t got);
      wrench_t want;
      if (expected_wrenches.size() == 0) begin
        $error("output word with no pending sample");
        errors++;
        return;
      end
      want = expected_wrenches.pop_front();
      checked++;
      for (int i = 0; i < 6; i++) begin
        if (got.axis[i] !== want.axis[i]) begin
          $error("%s: expected %0d, got %0d", axis_name(i), want.axis[i], got.axis[i]);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return expected_wrenches.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [RROW_W-1:0]     cfg_data_i;

  pgc_in_if  #(.WRENCH_WIDTH(WW), .ROT_WIDTH(RW)) in_if ();
  pgc_out_if #(.WRENCH_WIDTH(WW))                 out_if ();

  payload_gravity_compensation #(
    .WRENCH_WIDTH(WW),
    .ROT_WIDTH   (RW)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  compensation_model model = new();
  bit rx_fast;
  bit hold_req;
  int n_sent;
  int n_configs;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // stall watchdog: cycles without any handshake
  always @(negedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("payload_gravity_compensation: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, full-rate stretches and one long hold
  initial begin : receiver
    int stall;
    wrench_t got;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (rx_fast) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 18);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(negedge clk_i); while (!out_if.valid);
      got.axis[0] = out_if.comp_force_x;
      got.axis[1] = out_if.comp_force_y;
      got.axis[2] = out_if.comp_force_z;
      got.axis[3] = out_if.comp_torque_x;
      got.axis[4] = out_if.comp_torque_y;
      got.axis[5] = out_if.comp_torque_z;
      @(posedge clk_i);
      model.check_wrench(got);
    end
  end

  task automatic send_sample(input sample_t s, input int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.force_x    <= s.meas[0];
    in_if.force_y    <= s.meas[1];
    in_if.force_z    <= s.meas[2];
    in_if.torque_x   <= s.meas[3];
    in_if.torque_y   <= s.meas[4];
    in_if.torque_z   <= s.meas[5];
    in_if.ee_rot_r20 <= s.e[0];
    in_if.ee_rot_r21 <= s.e[1];
    in_if.ee_rot_r22 <= s.e[2];
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
    model.note_sample(s);
    n_sent++;
  endtask

  // stop offering and let every pending word come back
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (model.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RROW_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    model.write_reg(idx, data);
  endtask

  // junk in the unused upper bits must be dropped by the block
  task automatic program_regs(input logic [MASS_W-1:0] mass,
                              input logic signed [COM_W-1:0] cx, cy, cz,
                              input logic [RROW_W-1:0] r0, r1, r2, input bit sub);
    logic [RROW_W-1:0] junk;
    junk = RROW_W'({$urandom, $urandom});
    write_reg(CFG_MASS, {junk[RROW_W-1:MASS_W], mass});
    write_reg(CFG_COM_X, {junk[RROW_W-1:COM_W], cx});
    write_reg(CFG_COM_Y, {junk[RROW_W-1:COM_W], cy});
    write_reg(CFG_COM_Z, {junk[RROW_W-1:COM_W], cz});
    write_reg(CFG_ROT_ROW0, r0);
    write_reg(CFG_ROT_ROW1, r1);
    write_reg(CFG_ROT_ROW2, r2);
    write_reg(CFG_SUB_MODE, {junk[RROW_W-1:1], sub});
    cfg_we_i <= 1'b0;
    n_configs++;
  endtask

  function automatic sample_t directed_sample(int k);
    sample_t s;
    for (int i = 0; i < 6; i++) s.meas[i] = '0;
    for (int i = 0; i < 3; i++) s.e[i] = '0;
    case (k)
      1: begin
        for (int i = 0; i < 6; i++) s.meas[i] = WMAX[WW-1:0];
        for (int i = 0; i < 3; i++) s.e[i] = RMAX;
      end
      2: begin
        for (int i = 0; i < 6; i++) s.meas[i] = WMIN[WW-1:0];
        for (int i = 0; i < 3; i++) s.e[i] = RMIN;
      end
      3: begin
        for (int i = 0; i < 6; i++) s.meas[i] = (i < 3) ? WMAX[WW-1:0] : WMIN[WW-1:0];
        s.e[0] = UNIT;
      end
      4: s.e[1] = UNIT;
      5: begin
        for (int i = 0; i < 6; i++) s.meas[i] = i[0] ? WMAX[WW-1:0] : WMIN[WW-1:0];
        s.e[2] = -UNIT;
      end
      6: begin
        for (int i = 0; i < 6; i++) s.meas[i] = i[0] ? -24'sd1 : 24'sd1;
        s.e[0] = RMIN;
        s.e[1] = RMAX;
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic signed [WW-1:0] rand_meas();
    logic signed [WW-1:0] v;
    v = WW'($urandom);
    case ($urandom_range(0, 5))
      0: return WMAX[WW-1:0];
      1: return WMIN[WW-1:0];
      2, 3: return v >>> $urandom_range(1, 16);
      default: return v;
    endcase
  endfunction

  function automatic logic signed [RW-1:0] rand_rot_entry();
    logic signed [RW-1:0] v;
    v = RW'($urandom);
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? UNIT : -UNIT;
      1: return v >>> $urandom_range(1, 8);
      default: return v;
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    for (int i = 0; i < 6; i++) s.meas[i] = rand_meas();
    for (int i = 0; i < 3; i++) s.e[i] = rand_rot_entry();
    return s;
  endfunction

  function automatic logic [RROW_W-1:0] rand_rot_row();
    logic [RROW_W-1:0] row;
    row = RROW_W'({$urandom, $urandom});
    if ($urandom_range(0, 1)) begin
      // signed permutation row, as a real rotation would give
      row = '0;
      row[$urandom_range(0, 2)*RW +: RW] = $urandom_range(0, 1) ? UNIT : -UNIT;
    end
    return row;
  endfunction

  function automatic logic signed [COM_W-1:0] rand_com();
    logic signed [COM_W-1:0] v;
    v = COM_W'($urandom);
    case ($urandom_range(0, 4))
      0: return RMAX;
      1: return RMIN;
      2: return v >>> $urandom_range(1, 10);
      default: return v;
    endcase
  endfunction

  task automatic random_config(input bit sub);
    logic [MASS_W-1:0] mass;
    case ($urandom_range(0, 4))
      0: mass = '0;
      1: mass = '1;
      2: mass = MASS_W'($urandom_range(0, 4096));
      default: mass = MASS_W'($urandom);
    endcase
    program_regs(mass, rand_com(), rand_com(), rand_com(),
                 rand_rot_row(), rand_rot_row(), rand_rot_row(), sub);
  endtask

  initial begin : stimulus
    bit tx_fast;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_MASS;
    cfg_data_i    <= '0;
    in_if.valid      <= 1'b0;
    in_if.force_x    <= '0;
    in_if.force_y    <= '0;
    in_if.force_z    <= '0;
    in_if.torque_x   <= '0;
    in_if.torque_y   <= '0;
    in_if.torque_z   <= '0;
    in_if.ee_rot_r20 <= '0;
    in_if.ee_rot_r21 <= '0;
    in_if.ee_rot_r22 <= '0;
    rx_fast  = 1'b0;
    hold_req = 1'b0;
    n_sent = 0;
    n_configs = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words under reset values, then at the register extremes in both modes
    for (int k = 0; k < 7; k++) send_sample(directed_sample(k), $urandom_range(0, 18));
    wait_idle();
    program_regs('1, RMAX, RMIN, RMAX, {RMAX, RMIN, RMAX}, {RMIN, RMAX, RMIN},
                 {UNIT, 18'sd0, 18'sd0}, 1'b1);
    for (int k = 0; k < 7; k++) send_sample(directed_sample(k), $urandom_range(0, 18));
    wait_idle();
    program_regs('1, RMIN, RMAX, RMIN, {RMIN, RMIN, RMIN}, {RMAX, RMAX, RMAX},
                 {RMIN, RMAX, RMIN}, 1'b0);
    for (int k = 0; k < 7; k++) send_sample(directed_sample(k), $urandom_range(0, 18));
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      random_config(p[0]);
      tx_fast = (p % 4 == 1) || (p % 4 == 2);
      rx_fast = (p % 4 == 1) || (p % 4 == 3);
      // long output hold while the sender keeps pushing, so the input backs up
      if (p == 5) begin
        tx_fast = 1'b1;
        hold_req = 1'b1;
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        send_sample(rand_sample(), tx_fast ? 0 : $urandom_range(0, 18));
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("sent %0d sensor words over %0d register settings, %0d words checked",
             n_sent, n_configs, model.checked);
    $display("covered add and subtract modes, saturation, long output hold");
    if (model.errors == 0 && model.outstanding() == 0) begin
      $display("payload_gravity_compensation: match");
    end else begin
      $display("payload_gravity_compensation: mismatch");
    end
    $finish;
  end

endmodule
